[src/tlbp_pkg.sv]
// Shared types, constants and helpers of the two-level branch predictor.
package tlbp_pkg;

  localparam int TABLE_INDEX_BITS_DEF = 10;
  localparam int HISTORY_ENTRIES_DEF  = 64;
  localparam int ADDR_WIDTH_DEF       = 32;

  localparam int ADDR_BITS_W = 4;
  localparam int HIST_BITS_W = 4;
  localparam int LOCAL_SEL_W = 3;
  localparam int SEL_LOW_W   = (2 ** LOCAL_SEL_W) - 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int COUNT_W     = 32;
  localparam int CTR_W       = 2;

  localparam logic [ADDR_BITS_W-1:0] ADDRESS_BITS_RST      = 4'd5;
  localparam logic [HIST_BITS_W-1:0] HISTORY_BITS_RST      = 4'd5;
  localparam logic [LOCAL_SEL_W-1:0] LOCAL_SELECT_BITS_RST = 3'd0;

  localparam logic [CTR_W-1:0] CTR_STRONG_TAKEN     = 2'd3;
  localparam logic [CTR_W-1:0] CTR_STRONG_NOT_TAKEN = 2'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADDRESS_BITS      = 2'd0,
    CFG_HISTORY_BITS      = 2'd1,
    CFG_LOCAL_SELECT_BITS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ADDR_BITS_W-1:0] address_bits;
    logic [HIST_BITS_W-1:0] history_bits;
    logic [LOCAL_SEL_W-1:0] local_select_bits;
  } cfg_t;

  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

[src/tlbp_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
module tlbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/tlbp_seq.sv]
// Sequencer: clearing pass, history and counter read-modify-write, running totals.
module tlbp_seq #(
  parameter int TABLE_INDEX_BITS = tlbp_pkg::TABLE_INDEX_BITS_DEF,
  parameter int HISTORY_ENTRIES  = tlbp_pkg::HISTORY_ENTRIES_DEF,
  parameter int ADDR_WIDTH       = tlbp_pkg::ADDR_WIDTH_DEF,
  parameter int HIDX_W           = tlbp_pkg::idx_w(HISTORY_ENTRIES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tlbp_pkg::cfg_t                cfg_i,
  input  logic                          start_i,
  input  logic [ADDR_WIDTH-1:0]         branch_addr_i,
  input  logic                          taken_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic                          predicted_taken_o,
  output logic                          mispredicted_o,
  output logic                          config_error_o,
  output logic [tlbp_pkg::COUNT_W-1:0]  miss_total_o,
  output logic [tlbp_pkg::COUNT_W-1:0]  branch_total_o,
  output logic                          hist_we_o,
  output logic [HIDX_W-1:0]             hist_waddr_o,
  output logic [TABLE_INDEX_BITS-1:0]   hist_wdata_o,
  output logic                          hist_re_o,
  output logic [HIDX_W-1:0]             hist_raddr_o,
  input  logic [TABLE_INDEX_BITS-1:0]   hist_rdata_i,
  output logic                          ctr_we_o,
  output logic [TABLE_INDEX_BITS-1:0]   ctr_waddr_o,
  output logic [tlbp_pkg::CTR_W-1:0]    ctr_wdata_o,
  output logic                          ctr_re_o,
  output logic [TABLE_INDEX_BITS-1:0]   ctr_raddr_o,
  input  logic [tlbp_pkg::CTR_W-1:0]    ctr_rdata_i
);

  localparam int T         = TABLE_INDEX_BITS;
  localparam int SEL_W     = tlbp_pkg::SEL_LOW_W;
  localparam int SEL_N     = 2 ** SEL_W;
  localparam int EXT_W     = (ADDR_WIDTH > T) ? ((ADDR_WIDTH > SEL_W) ? ADDR_WIDTH : SEL_W)
                                              : ((T > SEL_W) ? T : SEL_W);
  localparam int CTR_DEPTH = 2 ** T;
  localparam int CLR_N     = (CTR_DEPTH > HISTORY_ENTRIES) ? CTR_DEPTH : HISTORY_ENTRIES;
  localparam int CLR_W     = $clog2(CLR_N) + 1;
  localparam int SUM_W     = tlbp_pkg::ADDR_BITS_W + 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HIST,
    S_CTR
  } state_e;

  state_e                        state_q;
  logic [CLR_W-1:0]              clr_q;
  logic [T-1:0]                  row_q;
  logic                          taken_q;
  logic [HIDX_W-1:0]             hidx_q;
  logic [T-1:0]                  hist_q;
  logic [T-1:0]                  tidx_q;
  logic                          done_q;
  logic                          pred_q;
  logic                          miss_flag_q;
  logic                          err_q;
  logic [tlbp_pkg::COUNT_W-1:0]  miss_q;
  logic [tlbp_pkg::COUNT_W-1:0]  branch_q;

  logic [HIDX_W-1:0]             hmod_tab [SEL_N];
  logic [EXT_W-1:0]              addr_ext;
  logic [SEL_W-1:0]              sel_mask;
  logic [SEL_W-1:0]              sel_low;
  logic [HIDX_W-1:0]             hidx;
  logic                          cfg_err;
  logic [T-1:0]                  col_mask;
  logic [T-1:0]                  tidx;
  logic                          pred;
  logic                          miss;
  logic [tlbp_pkg::CTR_W-1:0]    ctr_next;
  logic                          accept;

  for (genvar g = 0; g < SEL_N; g++) begin : g_hmod
    assign hmod_tab[g] = HIDX_W'(g % HISTORY_ENTRIES);
  end

  assign addr_ext = EXT_W'(branch_addr_i);
  assign sel_mask = (SEL_W'(1) << cfg_i.local_select_bits) - SEL_W'(1);
  assign sel_low  = addr_ext[SEL_W-1:0] & sel_mask;
  assign hidx     = hmod_tab[sel_low];
  assign cfg_err  = (SUM_W'(cfg_i.address_bits) + SUM_W'(cfg_i.history_bits)) != SUM_W'(T);
  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && (state_q == S_IDLE);

  assign col_mask = (T'(1) << cfg_i.history_bits) - T'(1);
  assign tidx     = (row_q << cfg_i.history_bits) | (hist_rdata_i & col_mask);

  assign pred = ctr_rdata_i[1];
  assign miss = pred != taken_q;

  always_comb begin
    ctr_next = ctr_rdata_i;
    if (taken_q) begin
      if (ctr_rdata_i != tlbp_pkg::CTR_STRONG_TAKEN) begin
        ctr_next = ctr_rdata_i + tlbp_pkg::CTR_W'(1);
      end
    end else if (ctr_rdata_i != tlbp_pkg::CTR_STRONG_NOT_TAKEN) begin
      ctr_next = ctr_rdata_i - tlbp_pkg::CTR_W'(1);
    end
  end

  always_comb begin
    hist_we_o    = 1'b0;
    hist_waddr_o = hidx_q;
    hist_wdata_o = {hist_q[T-2:0], taken_q};
    ctr_we_o     = 1'b0;
    ctr_waddr_o  = tidx_q;
    ctr_wdata_o  = ctr_next;
    if (state_q == S_CLEAR) begin
      hist_we_o    = clr_q < CLR_W'(HISTORY_ENTRIES);
      hist_waddr_o = clr_q[HIDX_W-1:0];
      hist_wdata_o = '0;
      ctr_we_o     = clr_q < CLR_W'(CTR_DEPTH);
      ctr_waddr_o  = clr_q[T-1:0];
      ctr_wdata_o  = tlbp_pkg::CTR_STRONG_TAKEN;
    end else if (state_q == S_CTR) begin
      hist_we_o = 1'b1;
      ctr_we_o  = 1'b1;
    end
  end

  assign hist_re_o    = accept && !cfg_err;
  assign hist_raddr_o = hidx;
  assign ctr_re_o     = (state_q == S_HIST);
  assign ctr_raddr_o  = tidx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      done_q      <= 1'b0;
      pred_q      <= 1'b0;
      miss_flag_q <= 1'b0;
      err_q       <= 1'b0;
      miss_q      <= '0;
      branch_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + CLR_W'(1);
          if (clr_q == CLR_W'(CLR_N - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            if (cfg_err) begin
              done_q      <= 1'b1;
              pred_q      <= 1'b0;
              miss_flag_q <= 1'b0;
              err_q       <= 1'b1;
            end else begin
              state_q <= S_HIST;
            end
          end
        end
        S_HIST: begin
          state_q <= S_CTR;
        end
        S_CTR: begin
          state_q     <= S_IDLE;
          done_q      <= 1'b1;
          pred_q      <= pred;
          miss_flag_q <= miss;
          err_q       <= 1'b0;
          if (miss && (miss_q != '1)) begin
            miss_q <= miss_q + tlbp_pkg::COUNT_W'(1);
          end
          if (branch_q != '1) begin
            branch_q <= branch_q + tlbp_pkg::COUNT_W'(1);
          end
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q   <= addr_ext[T-1:0];
      taken_q <= taken_i;
      hidx_q  <= hidx;
    end
    if (state_q == S_HIST) begin
      hist_q <= hist_rdata_i;
      tidx_q <= tidx;
    end
  end

  assign done_o            = done_q;
  assign predicted_taken_o = pred_q;
  assign mispredicted_o    = miss_flag_q;
  assign config_error_o    = err_q;
  assign miss_total_o      = miss_q;
  assign branch_total_o    = branch_q;

  a_done_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) == S_CTR) || (($past(state_q) == S_IDLE) && $past(start_i)))
    else $error("result strobe without a finished transaction");

  a_miss_le_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    miss_q <= branch_q)
    else $error("miss total exceeds branch total");

  a_branch_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (branch_q != $past(branch_q)) |-> $past(state_q == S_CTR))
    else $error("branch total moved outside counter update");

  a_ctr_read_then_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctr_re_o |=> (state_q == S_CTR) && ctr_we_o && hist_we_o)
    else $error("counter read not followed by write-back");

endmodule

[src/two_level_branch_predictor_unit.sv]
// Top level of the two-level adaptive branch predictor.
//
// Input channel: a resolved branch (branch_addr_i, taken_i) is taken at a rising
// edge with start_i high and busy_o low. One result per transaction appears on
// the result ports for a single cycle, marked by done_o; the receiver cannot stall.
// Configuration channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i,
// always ready; write only while no transaction is outstanding.
// With a valid split a transaction passes through the history memory read,
// the counter memory read and the write-back before the result strobe is
// registered; busy_o stays high until the write-back, so no new transaction
// is taken before then. With a bad split the result follows in the next
// cycle and a transaction is taken every cycle.
// Reset: a clearing pass over max(2**TABLE_INDEX_BITS, HISTORY_ENTRIES) addresses
// (1024 by default) sets every counter to strongly taken and every history to
// zero; busy_o stays high throughout, configuration writes are still taken.
module two_level_branch_predictor_unit #(
  parameter int TABLE_INDEX_BITS = tlbp_pkg::TABLE_INDEX_BITS_DEF,
  parameter int HISTORY_ENTRIES  = tlbp_pkg::HISTORY_ENTRIES_DEF,
  parameter int ADDR_WIDTH       = tlbp_pkg::ADDR_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tlbp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tlbp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [ADDR_WIDTH-1:0]           branch_addr_i,
  input  logic                            taken_i,
  output logic                            done_o,
  output logic                            predicted_taken_o,
  output logic                            mispredicted_o,
  output logic                            config_error_o,
  output logic [tlbp_pkg::COUNT_W-1:0]    miss_total_o,
  output logic [tlbp_pkg::COUNT_W-1:0]    branch_total_o
);

  localparam int HIDX_W = tlbp_pkg::idx_w(HISTORY_ENTRIES);
  localparam int T      = TABLE_INDEX_BITS;

  tlbp_pkg::cfg_t cfg_q;

  logic                       hist_we;
  logic [HIDX_W-1:0]          hist_waddr;
  logic [T-1:0]               hist_wdata;
  logic                       hist_re;
  logic [HIDX_W-1:0]          hist_raddr;
  logic [T-1:0]               hist_rdata;
  logic                       ctr_we;
  logic [T-1:0]               ctr_waddr;
  logic [tlbp_pkg::CTR_W-1:0] ctr_wdata;
  logic                       ctr_re;
  logic [T-1:0]               ctr_raddr;
  logic [tlbp_pkg::CTR_W-1:0] ctr_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.address_bits      <= tlbp_pkg::ADDRESS_BITS_RST;
      cfg_q.history_bits      <= tlbp_pkg::HISTORY_BITS_RST;
      cfg_q.local_select_bits <= tlbp_pkg::LOCAL_SELECT_BITS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (tlbp_pkg::cfg_idx_e'(cfg_index_i))
        tlbp_pkg::CFG_ADDRESS_BITS: begin
          cfg_q.address_bits <= cfg_data_i[tlbp_pkg::ADDR_BITS_W-1:0];
        end
        tlbp_pkg::CFG_HISTORY_BITS: begin
          cfg_q.history_bits <= cfg_data_i[tlbp_pkg::HIST_BITS_W-1:0];
        end
        tlbp_pkg::CFG_LOCAL_SELECT_BITS: begin
          cfg_q.local_select_bits <= cfg_data_i[tlbp_pkg::LOCAL_SEL_W-1:0];
        end
        default: ;
      endcase
    end
  end

  tlbp_seq #(
    .TABLE_INDEX_BITS (TABLE_INDEX_BITS),
    .HISTORY_ENTRIES  (HISTORY_ENTRIES),
    .ADDR_WIDTH       (ADDR_WIDTH),
    .HIDX_W           (HIDX_W)
  ) u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .start_i           (start_i),
    .branch_addr_i     (branch_addr_i),
    .taken_i           (taken_i),
    .busy_o            (busy_o),
    .done_o            (done_o),
    .predicted_taken_o (predicted_taken_o),
    .mispredicted_o    (mispredicted_o),
    .config_error_o    (config_error_o),
    .miss_total_o      (miss_total_o),
    .branch_total_o    (branch_total_o),
    .hist_we_o         (hist_we),
    .hist_waddr_o      (hist_waddr),
    .hist_wdata_o      (hist_wdata),
    .hist_re_o         (hist_re),
    .hist_raddr_o      (hist_raddr),
    .hist_rdata_i      (hist_rdata),
    .ctr_we_o          (ctr_we),
    .ctr_waddr_o       (ctr_waddr),
    .ctr_wdata_o       (ctr_wdata),
    .ctr_re_o          (ctr_re),
    .ctr_raddr_o       (ctr_raddr),
    .ctr_rdata_i       (ctr_rdata)
  );

  tlbp_ram #(
    .WIDTH (T),
    .DEPTH (HISTORY_ENTRIES),
    .AW    (HIDX_W)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  tlbp_ram #(
    .WIDTH (tlbp_pkg::CTR_W),
    .DEPTH (2 ** T),
    .AW    (T)
  ) u_ctr_ram (
    .clk_i   (clk_i),
    .we_i    (ctr_we),
    .waddr_i (ctr_waddr),
    .wdata_i (ctr_wdata),
    .re_i    (ctr_re),
    .raddr_i (ctr_raddr),
    .rdata_o (ctr_rdata)
  );

endmodule

[verif/tlbp_outcome_checker.sv]
`timescale 1ns / 100ps
// Checker that tracks the predictor's tables and compares every result transaction.
module tlbp_outcome_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_i,
  input  logic [tlbp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [tlbp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  start_i,
  input  logic                                  busy_i,
  input  logic [tlbp_pkg::ADDR_WIDTH_DEF-1:0]   branch_addr_i,
  input  logic                                  taken_i,
  input  logic                                  done_i,
  input  logic                                  predicted_taken_i,
  input  logic                                  mispredicted_i,
  input  logic                                  config_error_i,
  input  logic [tlbp_pkg::COUNT_W-1:0]          miss_total_i,
  input  logic [tlbp_pkg::COUNT_W-1:0]          branch_total_i,
  output int                                    mismatch_count_o,
  output int                                    outstanding_o
);

  localparam int TIB          = tlbp_pkg::TABLE_INDEX_BITS_DEF;
  localparam int TABLE_SIZE   = 1 << TIB;
  localparam int HIST_ENTRIES = tlbp_pkg::HISTORY_ENTRIES_DEF;
  localparam int AW           = tlbp_pkg::ADDR_WIDTH_DEF;
  localparam int CW           = tlbp_pkg::COUNT_W;

  typedef struct packed {
    logic          predicted_taken;
    logic          mispredicted;
    logic          config_error;
    logic [CW-1:0] miss_total;
    logic [CW-1:0] branch_total;
  } outcome_t;

  logic [tlbp_pkg::CTR_W-1:0] ctr_tbl [TABLE_SIZE];
  logic [TIB-1:0]             hist_tbl [HIST_ENTRIES];
  logic [CW-1:0]              miss_cnt;
  logic [CW-1:0]              branch_cnt;
  tlbp_pkg::cfg_t             cfg;
  outcome_t                   expected_outcomes [$];
  outcome_t                   oldest;
  outcome_t                   incoming;
  int                         mismatches = 0;

  assign mismatch_count_o = mismatches;

  function automatic outcome_t predict_outcome(input logic [AW-1:0] addr, input logic taken);
    outcome_t                   res;
    logic [63:0]                sel;
    int unsigned                hidx;
    int unsigned                row;
    int unsigned                col;
    int unsigned                tidx;
    logic [tlbp_pkg::CTR_W-1:0] ctr;
    res = '0;
    if (int'(cfg.address_bits) + int'(cfg.history_bits) != TIB) begin
      res.config_error = 1'b1;
      res.miss_total   = miss_cnt;
      res.branch_total = branch_cnt;
      return res;
    end
    sel  = 64'(addr) & ((64'd1 << cfg.local_select_bits) - 64'd1);
    hidx = int'(sel % HIST_ENTRIES);
    row  = 32'(addr) & ((32'd1 << cfg.address_bits) - 32'd1);
    col  = 32'(hist_tbl[hidx]) & ((32'd1 << cfg.history_bits) - 32'd1);
    tidx = ((row << cfg.history_bits) | col) & (TABLE_SIZE - 1);
    ctr  = ctr_tbl[tidx];
    res.predicted_taken = (ctr >= 2);
    res.mispredicted    = (res.predicted_taken != taken);
    if (taken && ctr != tlbp_pkg::CTR_STRONG_TAKEN) begin
      ctr++;
    end else if (!taken && ctr != tlbp_pkg::CTR_STRONG_NOT_TAKEN) begin
      ctr--;
    end
    ctr_tbl[tidx]  = ctr;
    hist_tbl[hidx] = {hist_tbl[hidx][TIB-2:0], taken};
    if (res.mispredicted && miss_cnt != '1) begin
      miss_cnt++;
    end
    if (branch_cnt != '1) begin
      branch_cnt++;
    end
    res.miss_total   = miss_cnt;
    res.branch_total = branch_cnt;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [CW-1:0] exp_v,
                                      input logic [CW-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SIZE; i++) ctr_tbl[i] = tlbp_pkg::CTR_STRONG_TAKEN;
      for (int i = 0; i < HIST_ENTRIES; i++) hist_tbl[i] = '0;
      miss_cnt   = '0;
      branch_cnt = '0;
      cfg.address_bits      = tlbp_pkg::ADDRESS_BITS_RST;
      cfg.history_bits      = tlbp_pkg::HISTORY_BITS_RST;
      cfg.local_select_bits = tlbp_pkg::LOCAL_SELECT_BITS_RST;
      expected_outcomes.delete();
      outstanding_o = 0;
    end else begin
      if (done_i === 1'b1) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: result transaction with none outstanding: expected none, actual %0h",
                   $time, {predicted_taken_i, mispredicted_i, config_error_i});
          mismatches++;
        end else begin
          oldest = expected_outcomes.pop_front();
          check_field("predicted_taken", 32'(oldest.predicted_taken), 32'(predicted_taken_i));
          check_field("mispredicted", 32'(oldest.mispredicted), 32'(mispredicted_i));
          check_field("config_error", 32'(oldest.config_error), 32'(config_error_i));
          check_field("miss_total", oldest.miss_total, miss_total_i);
          check_field("branch_total", oldest.branch_total, branch_total_i);
        end
      end
      if (cfg_valid_i === 1'b1 && cfg_ready_i === 1'b1) begin
        unique case (tlbp_pkg::cfg_idx_e'(cfg_index_i))
          tlbp_pkg::CFG_ADDRESS_BITS:
            cfg.address_bits = cfg_data_i[tlbp_pkg::ADDR_BITS_W-1:0];
          tlbp_pkg::CFG_HISTORY_BITS:
            cfg.history_bits = cfg_data_i[tlbp_pkg::HIST_BITS_W-1:0];
          tlbp_pkg::CFG_LOCAL_SELECT_BITS:
            cfg.local_select_bits = cfg_data_i[tlbp_pkg::LOCAL_SEL_W-1:0];
          default: ;
        endcase
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        incoming = predict_outcome(branch_addr_i, taken_i);
        expected_outcomes.insert(expected_outcomes.size(), incoming);
      end
      outstanding_o = expected_outcomes.size();
    end
  end

endmodule

[verif/tb_two_level_branch_predictor_unit.sv]
`timescale 1ns / 100ps
// Testbench top of the two-level branch predictor: stimulus, watchdog and verdict.
module tb_two_level_branch_predictor_unit;

  localparam logic [tlbp_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int IDLE_PAD       = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 305;
  localparam int POOL_SIZE      = 8;
  localparam int AW             = tlbp_pkg::ADDR_WIDTH_DEF;
  localparam int DW             = tlbp_pkg::CFG_DATA_W;

  logic                               clk_i         = 1'b0;
  logic                               rst_ni        = 1'b0;
  logic                               cfg_valid_i   = 1'b0;
  logic [tlbp_pkg::CFG_IDX_W-1:0]     cfg_index_i   = '0;
  logic [DW-1:0]                      cfg_data_i    = '0;
  logic                               start_i       = 1'b0;
  logic [AW-1:0]                      branch_addr_i = '0;
  logic                               taken_i       = 1'b0;
  logic                               cfg_ready_o;
  logic                               busy_o;
  logic                               done_o;
  logic                               predicted_taken_o;
  logic                               mispredicted_o;
  logic                               config_error_o;
  logic [tlbp_pkg::COUNT_W-1:0]       miss_total_o;
  logic [tlbp_pkg::COUNT_W-1:0]       branch_total_o;

  int mismatch_count;
  int outstanding;
  int burst_left   = 0;
  int stall_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  two_level_branch_predictor_unit i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .branch_addr_i     (branch_addr_i),
    .taken_i           (taken_i),
    .done_o            (done_o),
    .predicted_taken_o (predicted_taken_o),
    .mispredicted_o    (mispredicted_o),
    .config_error_o    (config_error_o),
    .miss_total_o      (miss_total_o),
    .branch_total_o    (branch_total_o)
  );

  tlbp_outcome_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .start_i           (start_i),
    .busy_i            (busy_o),
    .branch_addr_i     (branch_addr_i),
    .taken_i           (taken_i),
    .done_i            (done_o),
    .predicted_taken_i (predicted_taken_o),
    .mispredicted_i    (mispredicted_o),
    .config_error_i    (config_error_o),
    .miss_total_i      (miss_total_o),
    .branch_total_i    (branch_total_o),
    .mismatch_count_o  (mismatch_count),
    .outstanding_o     (outstanding)
  );

  always @(posedge clk_i) begin
    if ((start_i && busy_o === 1'b0) || done_o === 1'b1 ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("** two_level_branch_predictor_unit: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input logic [tlbp_pkg::CFG_IDX_W-1:0] idx, input logic [DW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_split(input logic [DW-1:0] p, input logic [DW-1:0] m,
                           input logic [DW-1:0] k);
    write_reg(tlbp_pkg::CFG_ADDRESS_BITS, p);
    write_reg(tlbp_pkg::CFG_HISTORY_BITS, m);
    write_reg(tlbp_pkg::CFG_LOCAL_SELECT_BITS, k);
  endtask

  task automatic send_branch(input logic [AW-1:0] addr, input logic taken);
    int gap;
    if (burst_left == 0) begin
      if (start_i) begin
        start_i <= 1'b0;
        gap = $urandom_range(1, 12);
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 16);
    end
    start_i       <= 1'b1;
    branch_addr_i <= addr;
    taken_i       <= taken;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    @(negedge clk_i);
    burst_left--;
  endtask

  // drop start, drain outstanding transactions and let the pipeline empty
  task automatic settle();
    start_i    <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (IDLE_PAD) @(negedge clk_i);
  endtask

  initial begin
    logic [AW-1:0] pool_addr [POOL_SIZE];
    logic [7:0]    pool_pat  [POOL_SIZE];
    int            pool_pos  [POOL_SIZE];
    int            sel;
    int            p;
    int            m;
    logic [AW-1:0] addr;
    logic          taken;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    repeat (2) send_branch('0, 1'b0);
    repeat (2) send_branch('1, 1'b1);

    // full address row, no history: drive one counter to both saturation points
    settle();
    set_split(4'd10, 4'd0, 4'd0);
    repeat (4) send_branch(32'h0000_03FF, 1'b0);
    repeat (4) send_branch(32'h0000_03FF, 1'b1);

    // wide write keeps 7 select bits, which wrap onto the history table
    settle();
    set_split(4'd0, 4'd10, 4'hF);
    repeat (3) begin
      send_branch(32'h0000_007F, 1'b1);
      send_branch(32'h8000_003F, 1'b0);
    end

    settle();
    set_split(4'hF, 4'd10, 4'd6);
    write_reg(CFG_IDX_SPARE, 4'hA);
    send_branch(32'h1234_5678, 1'b1);
    send_branch('1, 1'b0);

    settle();
    set_split(4'd4, 4'd5, 4'd6);
    send_branch(32'hDEAD_BEEF, 1'b1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      p = $urandom_range(0, 10);
      m = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : 10 - p;
      set_split(4'(p), 4'(m), {1'($urandom_range(0, 1)), 3'($urandom_range(0, 7))});
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_IDX_SPARE, 4'($urandom));
      end
      for (int i = 0; i < POOL_SIZE; i++) begin
        pool_addr[i] = $urandom;
        pool_pat[i]  = 8'($urandom);
        pool_pos[i]  = 0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 3) != 0) begin
          sel   = $urandom_range(0, POOL_SIZE - 1);
          addr  = pool_addr[sel];
          taken = pool_pat[sel][pool_pos[sel]];
          pool_pos[sel] = (pool_pos[sel] + 1) % 8;
          if ($urandom_range(0, 9) == 0) begin
            taken = !taken;
          end
        end else begin
          addr  = $urandom;
          taken = 1'($urandom_range(0, 1));
        end
        send_branch(addr, taken);
      end
    end

    settle();
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("** two_level_branch_predictor_unit: PASSED **");
    end else begin
      $display("** two_level_branch_predictor_unit: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
src/tlbp_pkg.sv
src/tlbp_ram.sv
src/tlbp_seq.sv
src/two_level_branch_predictor_unit.sv
verif/tlbp_outcome_checker.sv
verif/tb_two_level_branch_predictor_unit.sv
